>>> sv/tlwcs_pkg.sv
// ----------------------------------------------------------------------------
// tlwcs_pkg
// Shared types and constants of the two-lane weighted chunk scheduler.
// ----------------------------------------------------------------------------
package tlwcs_pkg;

	localparam int IDX_W   = 12;
	localparam int CNT_W   = 13;
	localparam int SHARE_W = 4;
	localparam int TOTAL_W = 32;
	localparam int PROD_W  = TOTAL_W + SHARE_W;
	localparam int WORD_W  = 64;
	localparam int WORD_LW = 6;

	localparam logic [CNT_W-1:0]   CHUNK_COUNT_RST    = 13'd4096;
	localparam logic [SHARE_W-1:0] BACKFILL_SHARE_RST = 4'd3;
	localparam logic [SHARE_W-1:0] LIVE_SHARE_RST     = 4'd7;

	localparam logic LANE_LIVE = 1'b0;
	localparam logic LANE_BACK = 1'b1;

	typedef enum logic [1:0] {
		ACT_NEED     = 2'd0,
		ACT_ANNOUNCE = 2'd1,
		ACT_PICK     = 2'd2,
		ACT_UNUSED   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OP_NEED,
		OP_ANNOUNCE,
		OP_PICK,
		OP_REJECT
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_WAIT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_CHUNK_COUNT    = 2'd0,
		CFG_BACKFILL_SHARE = 2'd1,
		CFG_LIVE_SHARE     = 2'd2,
		CFG_HASHES_PRE     = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_NEED,
		B_SCAN,
		B_DECIDE,
		B_COMMIT,
		B_RESP
	} bstate_t;

	typedef struct packed {
		op_t              op;
		logic             lane;
		logic [IDX_W-1:0] from;
		logic [IDX_W-1:0] to;
		logic [CNT_W-1:0] hcount;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] index;
		logic             lane;
		logic             first;
	} result_t;

endpackage

>>> sv/tlwcs_fifo.sv
// ----------------------------------------------------------------------------
// tlwcs_fifo
// Small register queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module tlwcs_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

>>> sv/tlwcs_front.sv
// ----------------------------------------------------------------------------
// tlwcs_front
// Accepts input transactions, classifies them and queues commands.
// ----------------------------------------------------------------------------
module tlwcs_front #(
	parameter int MAX_CHUNKS = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [1:0]                           action,
	input  logic                                 lane,
	input  logic [tlwcs_pkg::IDX_W-1:0]          range_from,
	input  logic [tlwcs_pkg::IDX_W-1:0]          range_to,
	input  logic [tlwcs_pkg::CNT_W-1:0]          hash_count,
	input  logic [$clog2(MAX_CHUNKS+1)-1:0]      n,
	input  logic                                 hold,
	input  logic                                 cmd_pop,
	output tlwcs_pkg::cmd_t                      cmd,
	output logic                                 cmd_empty
);
	tlwcs_pkg::cmd_t                  cmd_in;
	logic [$bits(tlwcs_pkg::cmd_t)-1:0] q_rdata;
	logic                             q_full;
	logic                             bad_range;

	assign bad_range = (range_from > range_to) || (32'(range_to) >= 32'(n));

	always_comb begin
		cmd_in.lane   = lane;
		cmd_in.from   = range_from;
		cmd_in.to     = range_to;
		cmd_in.hcount = hash_count;
		case (tlwcs_pkg::action_t'(action))
			tlwcs_pkg::ACT_NEED: begin
				cmd_in.op = bad_range ? tlwcs_pkg::OP_REJECT : tlwcs_pkg::OP_NEED;
			end
			tlwcs_pkg::ACT_ANNOUNCE: begin
				cmd_in.op = tlwcs_pkg::OP_ANNOUNCE;
			end
			tlwcs_pkg::ACT_PICK: begin
				cmd_in.op = tlwcs_pkg::OP_PICK;
			end
			default: begin
				cmd_in.op = tlwcs_pkg::OP_REJECT;
			end
		endcase
	end

	assign full = q_full || hold;
	assign cmd  = tlwcs_pkg::cmd_t'(q_rdata);

	tlwcs_fifo #(
		.W     ($bits(tlwcs_pkg::cmd_t)),
		.DEPTH (2)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !hold),
		.wdata  (cmd_in),
		.full   (q_full),
		.pop    (cmd_pop),
		.rdata  (q_rdata),
		.empty  (cmd_empty)
	);

endmodule

>>> sv/tlwcs_back.sv
// ----------------------------------------------------------------------------
// tlwcs_back
// Executes commands against the pending and sent bitmaps, word by word.
// ----------------------------------------------------------------------------
module tlwcs_back #(
	parameter int MAX_CHUNKS = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tlwcs_pkg::cmd_t                      cmd,
	input  logic                                 cmd_empty,
	output logic                                 cmd_pop,
	input  logic [$clog2(MAX_CHUNKS+1)-1:0]      n,
	input  logic [tlwcs_pkg::SHARE_W-1:0]        backfill_share,
	input  logic [tlwcs_pkg::SHARE_W-1:0]        live_share,
	input  logic                                 hashes_pre,
	output tlwcs_pkg::result_t                   res,
	output logic                                 res_push,
	input  logic                                 res_full,
	output logic                                 clearing
);
	localparam int IW = $clog2(MAX_CHUNKS);
	localparam int CW = $clog2(MAX_CHUNKS+1);
	localparam int WW = tlwcs_pkg::WORD_W;
	localparam int LW = tlwcs_pkg::WORD_LW;
	localparam int NW = (MAX_CHUNKS + WW - 1) / WW;
	localparam int AW = (NW > 1) ? $clog2(NW) : 1;
	localparam int TW = tlwcs_pkg::TOTAL_W;
	localparam int PW = tlwcs_pkg::PROD_W;

	function automatic logic [LW-1:0] low_bit(input logic [WW-1:0] w);
		logic [LW-1:0] r;
		r = '0;
		for (int i = WW-1; i >= 0; i--) begin
			if (w[i]) begin
				r = LW'(i);
			end
		end
		return r;
	endfunction

	tlwcs_pkg::bstate_t state_q, state_d;

	logic [WW-1:0] live_mem [NW];
	logic [WW-1:0] back_mem [NW];
	logic [WW-1:0] sent_mem [NW];
	logic [WW-1:0] live_rd_q, back_rd_q, sent_rd_q;

	logic          rd_en, we_live, we_back, we_sent;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [WW-1:0] wd_map, wd_sent;

	logic [AW:0]   ptr_q;
	logic          v_s1;
	logic [AW-1:0] a_s1;

	tlwcs_pkg::cmd_t    cmd_q;
	tlwcs_pkg::result_t res_q;
	logic [IW-1:0]      hint_l_q, hint_b_q;
	logic [TW-1:0]      tot_l_q, tot_b_q;
	logic [PW-1:0]      prod_l_q, prod_b_q;
	logic [CW-1:0]      bound_q;
	logic               fa_l_q, fh_l_q, fa_b_q, fh_b_q;
	logic [IW-1:0]      ia_l_q, ih_l_q, ia_b_q, ih_b_q;
	logic               use_live_q;
	logic [IW-1:0]      idx_q;

	logic [31:0]   from32, to32, n32, a32, hl32, hb32, idx32, sel32, hc32, hsat32;
	logic [AW:0]   ta_ext, fa_head;
	logic [WW-1:0] need_mask, nmask, hmask_l, hmask_b;
	logic [WW-1:0] wl, wlh, wb, wbh, map_rd;
	logic [LW-1:0] lo, hi;
	logic [31:0]   base32;
	logic          use_live, chosen_has, gated;
	logic [IW-1:0] sel_idx;
	logic [CW-1:0] gate;

	assign from32  = 32'(cmd_q.from);
	assign to32    = 32'(cmd_q.to);
	assign n32     = 32'(n);
	assign a32     = 32'(a_s1);
	assign hl32    = 32'(hint_l_q);
	assign hb32    = 32'(hint_b_q);
	assign idx32   = 32'(idx_q);
	assign ta_ext  = (AW+1)'(to32 >> LW);
	assign fa_head = (AW+1)'(32'(cmd.from) >> LW);
	assign base32  = a32 << LW;
	assign hc32    = 32'(cmd.hcount);
	assign hsat32  = (hc32 > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS) : hc32;
	assign map_rd  = (cmd_q.lane == tlwcs_pkg::LANE_BACK) ? back_rd_q : live_rd_q;

	always_comb begin
		lo = (a32 == (from32 >> LW)) ? from32[LW-1:0] : '0;
		hi = (a32 == (to32 >> LW)) ? to32[LW-1:0] : '1;
		for (int j = 0; j < WW; j++) begin
			need_mask[j] = (LW'(j) >= lo) && (LW'(j) <= hi);
			nmask[j]     = (a32 < (n32 >> LW)) ||
			               ((a32 == (n32 >> LW)) && (LW'(j) < n32[LW-1:0]));
			hmask_l[j]   = (a32 > (hl32 >> LW)) ||
			               ((a32 == (hl32 >> LW)) && (LW'(j) >= hl32[LW-1:0]));
			hmask_b[j]   = (a32 > (hb32 >> LW)) ||
			               ((a32 == (hb32 >> LW)) && (LW'(j) >= hb32[LW-1:0]));
		end
	end

	assign wl  = live_rd_q & nmask;
	assign wlh = wl & hmask_l;
	assign wb  = back_rd_q & nmask;
	assign wbh = wb & hmask_b;

	always_comb begin
		use_live   = fa_l_q && !(fa_b_q && (prod_b_q < prod_l_q));
		chosen_has = use_live ? fa_l_q : fa_b_q;
		if (use_live) begin
			sel_idx = fh_l_q ? ih_l_q : ia_l_q;
		end else begin
			sel_idx = fh_b_q ? ih_b_q : ia_b_q;
		end
		sel32 = 32'(sel_idx);
		gate  = hashes_pre ? n : bound_q;
		gated = (sel32 >= 32'(gate));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tlwcs_pkg::B_CLEAR: begin
				if (ptr_q == (AW+1)'(NW-1)) begin
					state_d = tlwcs_pkg::B_IDLE;
				end
			end
			tlwcs_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.op)
						tlwcs_pkg::OP_NEED: state_d = tlwcs_pkg::B_NEED;
						tlwcs_pkg::OP_PICK: state_d = tlwcs_pkg::B_SCAN;
						default:            state_d = tlwcs_pkg::B_RESP;
					endcase
				end
			end
			tlwcs_pkg::B_NEED: begin
				if (ptr_q > ta_ext && !v_s1) begin
					state_d = tlwcs_pkg::B_RESP;
				end
			end
			tlwcs_pkg::B_SCAN: begin
				if (ptr_q == (AW+1)'(NW) && !v_s1) begin
					state_d = tlwcs_pkg::B_DECIDE;
				end
			end
			tlwcs_pkg::B_DECIDE: begin
				state_d = (chosen_has && !gated) ? tlwcs_pkg::B_COMMIT : tlwcs_pkg::B_RESP;
			end
			tlwcs_pkg::B_COMMIT: begin
				state_d = tlwcs_pkg::B_RESP;
			end
			tlwcs_pkg::B_RESP: begin
				if (!res_full) begin
					state_d = tlwcs_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = tlwcs_pkg::B_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = ptr_q[AW-1:0];
		we_live  = 1'b0;
		we_back  = 1'b0;
		we_sent  = 1'b0;
		wr_addr  = ptr_q[AW-1:0];
		wd_map   = '0;
		wd_sent  = '0;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		case (state_q)
			tlwcs_pkg::B_CLEAR: begin
				we_live = 1'b1;
				we_back = 1'b1;
				we_sent = 1'b1;
			end
			tlwcs_pkg::B_IDLE: begin
				cmd_pop = !cmd_empty;
			end
			tlwcs_pkg::B_NEED: begin
				rd_en   = (ptr_q <= ta_ext);
				wr_addr = a_s1;
				wd_map  = map_rd | need_mask;
				we_live = v_s1 && (cmd_q.lane == tlwcs_pkg::LANE_LIVE);
				we_back = v_s1 && (cmd_q.lane == tlwcs_pkg::LANE_BACK);
			end
			tlwcs_pkg::B_SCAN: begin
				rd_en = (ptr_q < (AW+1)'(NW));
			end
			tlwcs_pkg::B_DECIDE: begin
				rd_en   = 1'b1;
				rd_addr = AW'(sel32 >> LW);
			end
			tlwcs_pkg::B_COMMIT: begin
				wr_addr = AW'(idx32 >> LW);
				wd_map  = (use_live_q ? live_rd_q : back_rd_q) &
				          ~(WW'(1) << idx32[LW-1:0]);
				wd_sent = sent_rd_q | (WW'(1) << idx32[LW-1:0]);
				we_live = use_live_q;
				we_back = !use_live_q;
				we_sent = 1'b1;
			end
			tlwcs_pkg::B_RESP: begin
				res_push = !res_full;
			end
			default: begin
			end
		endcase
	end

	assign clearing = (state_q == tlwcs_pkg::B_CLEAR);
	assign res      = res_q;

	always_ff @(posedge clk) begin
		if (we_live) begin
			live_mem[wr_addr] <= wd_map;
		end
		if (we_back) begin
			back_mem[wr_addr] <= wd_map;
		end
		if (we_sent) begin
			sent_mem[wr_addr] <= wd_sent;
		end
		if (rd_en) begin
			live_rd_q <= live_mem[rd_addr];
			back_rd_q <= back_mem[rd_addr];
			sent_rd_q <= sent_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tlwcs_pkg::B_CLEAR;
			ptr_q    <= '0;
			v_s1     <= 1'b0;
			hint_l_q <= '0;
			hint_b_q <= '0;
			tot_l_q  <= '0;
			tot_b_q  <= '0;
			bound_q  <= '0;
			fa_l_q   <= 1'b0;
			fh_l_q   <= 1'b0;
			fa_b_q   <= 1'b0;
			fh_b_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= rd_en && (state_q == tlwcs_pkg::B_NEED ||
			                     state_q == tlwcs_pkg::B_SCAN);
			case (state_q)
				tlwcs_pkg::B_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
				end
				tlwcs_pkg::B_IDLE: begin
					if (!cmd_empty) begin
						case (cmd.op)
							tlwcs_pkg::OP_NEED: begin
								ptr_q <= fa_head;
								if (cmd.lane == tlwcs_pkg::LANE_BACK) begin
									if (32'(cmd.from) < hb32) begin
										hint_b_q <= IW'(cmd.from);
									end
								end else begin
									if (32'(cmd.from) < hl32) begin
										hint_l_q <= IW'(cmd.from);
									end
								end
							end
							tlwcs_pkg::OP_PICK: begin
								ptr_q  <= '0;
								fa_l_q <= 1'b0;
								fh_l_q <= 1'b0;
								fa_b_q <= 1'b0;
								fh_b_q <= 1'b0;
							end
							tlwcs_pkg::OP_ANNOUNCE: begin
								if (hsat32 > 32'(bound_q)) begin
									bound_q <= CW'(hsat32);
								end
							end
							default: begin
							end
						endcase
					end
				end
				tlwcs_pkg::B_NEED: begin
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				tlwcs_pkg::B_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (v_s1) begin
						if (!fa_l_q && (|wl)) begin
							fa_l_q <= 1'b1;
						end
						if (!fh_l_q && (|wlh)) begin
							fh_l_q <= 1'b1;
						end
						if (!fa_b_q && (|wb)) begin
							fa_b_q <= 1'b1;
						end
						if (!fh_b_q && (|wbh)) begin
							fh_b_q <= 1'b1;
						end
					end
				end
				tlwcs_pkg::B_DECIDE: begin
					if (chosen_has) begin
						if (use_live) begin
							hint_l_q <= sel_idx;
						end else begin
							hint_b_q <= sel_idx;
						end
					end
				end
				tlwcs_pkg::B_COMMIT: begin
					if (use_live_q) begin
						if (tot_l_q != '1) begin
							tot_l_q <= tot_l_q + 1'b1;
						end
					end else begin
						if (tot_b_q != '1) begin
							tot_b_q <= tot_b_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		a_s1     <= rd_addr;
		prod_l_q <= PW'(tot_l_q) * PW'(backfill_share);
		prod_b_q <= PW'(tot_b_q) * PW'(live_share);
		if (state_q == tlwcs_pkg::B_SCAN && v_s1) begin
			if (!fa_l_q) begin
				ia_l_q <= IW'(base32 | 32'(low_bit(wl)));
			end
			if (!fh_l_q) begin
				ih_l_q <= IW'(base32 | 32'(low_bit(wlh)));
			end
			if (!fa_b_q) begin
				ia_b_q <= IW'(base32 | 32'(low_bit(wb)));
			end
			if (!fh_b_q) begin
				ih_b_q <= IW'(base32 | 32'(low_bit(wbh)));
			end
		end
		case (state_q)
			tlwcs_pkg::B_IDLE: begin
				cmd_q        <= cmd;
				res_q.index  <= '0;
				res_q.lane   <= tlwcs_pkg::LANE_LIVE;
				res_q.first  <= 1'b0;
				res_q.status <= (cmd.op == tlwcs_pkg::OP_REJECT) ?
				                tlwcs_pkg::ST_REJECT : tlwcs_pkg::ST_OK;
			end
			tlwcs_pkg::B_DECIDE: begin
				idx_q      <= sel_idx;
				use_live_q <= use_live;
				if (!chosen_has) begin
					res_q.status <= tlwcs_pkg::ST_EMPTY;
				end else if (gated) begin
					res_q.status <= tlwcs_pkg::ST_WAIT;
				end
			end
			tlwcs_pkg::B_COMMIT: begin
				res_q.status <= tlwcs_pkg::ST_OK;
				res_q.index  <= tlwcs_pkg::IDX_W'(idx_q);
				res_q.lane   <= use_live_q ? tlwcs_pkg::LANE_LIVE : tlwcs_pkg::LANE_BACK;
				res_q.first  <= !sent_rd_q[idx32[LW-1:0]];
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/two_lane_weighted_chunk_scheduler.sv
// ----------------------------------------------------------------------------
// two_lane_weighted_chunk_scheduler
// Picks chunks to send from a live and a backfill lane with weighted sharing.
//
// Input queue: push/full carries need, announce and pick transactions.
// Result queue: empty/pop carries exactly one result per input transaction.
// A short command queue sits between the classifying front and the engine,
// and a two-entry result queue decouples the engine from the receiver.
// Bitmaps are held in 64-bit words; the engine visits one word per cycle.
// Announce and rejected items go straight to their result; a need item
// visits the words its range touches; a pick scans all MAX_CHUNKS/64 words
// and adds a commit step when it sends a chunk.
// One item is executed at a time: the engine takes the next item only
// after the last one's result has been queued.
// After reset the engine clears all bitmaps, one word per cycle, and
// holds full high meanwhile; configuration is taken during that pass.
// When the receiver stalls, results stay queued and full rises once both
// queues are occupied.
// ----------------------------------------------------------------------------
module two_lane_weighted_chunk_scheduler #(
	parameter int MAX_CHUNKS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      action,
	input  logic                            lane,
	input  logic [tlwcs_pkg::IDX_W-1:0]     range_from,
	input  logic [tlwcs_pkg::IDX_W-1:0]     range_to,
	input  logic [tlwcs_pkg::CNT_W-1:0]     hash_count,
	output logic                            empty,
	input  logic                            pop,
	output logic [1:0]                      status,
	output logic [tlwcs_pkg::IDX_W-1:0]     chunk_index,
	output logic                            chunk_lane,
	output logic                            first_time,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [tlwcs_pkg::CNT_W-1:0]     cfg_data
);
	localparam int CW = $clog2(MAX_CHUNKS+1);

	logic [tlwcs_pkg::CNT_W-1:0]   chunk_count_q;
	logic [tlwcs_pkg::SHARE_W-1:0] backfill_share_q;
	logic [tlwcs_pkg::SHARE_W-1:0] live_share_q;
	logic                          hashes_pre_q;
	logic [CW-1:0]                 n;

	tlwcs_pkg::cmd_t    cmd;
	logic               cmd_empty, cmd_pop, hold;
	tlwcs_pkg::result_t res, res_out;
	logic               res_push, res_full;
	logic [$bits(tlwcs_pkg::result_t)-1:0] res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q    <= tlwcs_pkg::CHUNK_COUNT_RST;
			backfill_share_q <= tlwcs_pkg::BACKFILL_SHARE_RST;
			live_share_q     <= tlwcs_pkg::LIVE_SHARE_RST;
			hashes_pre_q     <= 1'b0;
		end else if (cfg_we) begin
			case (tlwcs_pkg::cfg_idx_t'(cfg_index))
				tlwcs_pkg::CFG_CHUNK_COUNT:    chunk_count_q    <= cfg_data;
				tlwcs_pkg::CFG_BACKFILL_SHARE: backfill_share_q <= cfg_data[3:0];
				tlwcs_pkg::CFG_LIVE_SHARE:     live_share_q     <= cfg_data[3:0];
				tlwcs_pkg::CFG_HASHES_PRE:     hashes_pre_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign n = (32'(chunk_count_q) > 32'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS) : CW'(chunk_count_q);

	tlwcs_front #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.lane       (lane),
		.range_from (range_from),
		.range_to   (range_to),
		.hash_count (hash_count),
		.n          (n),
		.hold       (hold),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd),
		.cmd_empty  (cmd_empty)
	);

	tlwcs_back #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cmd_empty      (cmd_empty),
		.cmd_pop        (cmd_pop),
		.n              (n),
		.backfill_share (backfill_share_q),
		.live_share     (live_share_q),
		.hashes_pre     (hashes_pre_q),
		.res            (res),
		.res_push       (res_push),
		.res_full       (res_full),
		.clearing       (hold)
	);

	tlwcs_fifo #(
		.W     ($bits(tlwcs_pkg::result_t)),
		.DEPTH (2)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_out     = tlwcs_pkg::result_t'(res_rdata);
	assign status      = res_out.status;
	assign chunk_index = res_out.index;
	assign chunk_lane  = res_out.lane;
	assign first_time  = res_out.first;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// two_lane_weighted_chunk_scheduler testbench
// Drives need, announce and pick transactions through the input queue and
// compares every result against a behavioral predictor of the scheduler,
// across several register settings, with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int NCH = 4096;

	logic clk, arst_n;
	logic push, full, empty;
	logic pop = 1'b0;
	logic [1:0] action;
	logic lane;
	logic [tlwcs_pkg::IDX_W-1:0] range_from, range_to;
	logic [tlwcs_pkg::CNT_W-1:0] hash_count;
	logic [1:0] status;
	logic [tlwcs_pkg::IDX_W-1:0] chunk_index;
	logic chunk_lane, first_time;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [tlwcs_pkg::CNT_W-1:0] cfg_data;

	two_lane_weighted_chunk_scheduler dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.lane(lane), .range_from(range_from), .range_to(range_to),
		.hash_count(hash_count), .empty(empty), .pop(pop), .status(status),
		.chunk_index(chunk_index), .chunk_lane(chunk_lane),
		.first_time(first_time), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [tlwcs_pkg::CNT_W-1:0] chunk_count_r;
	logic [tlwcs_pkg::SHARE_W-1:0] back_share_r, live_share_r;
	logic hashes_pre_r;
	bit live_map[NCH];
	bit back_map[NCH];
	bit sent_map[NCH];
	logic [tlwcs_pkg::CNT_W-1:0] live_hint, back_hint;
	logic [31:0] live_total, back_total;
	logic [tlwcs_pkg::CNT_W-1:0] boundary;

	tlwcs_pkg::result_t expected_q[$];
	int errors = 0;
	longint cycles = 0;
	int stall_len = 0;
	bit long_stall_req = 1'b0;
	bit long_stall_done = 1'b0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("two_lane_weighted_chunk_scheduler regression: fail");
			$finish;
		end
	end

	function automatic int eff_count();
		return (chunk_count_r > NCH) ? NCH : int'(chunk_count_r);
	endfunction

	function automatic int lowest_pending(bit back, int from, int n);
		for (int i = from; i < n; i++) begin
			if (back ? back_map[i] : live_map[i])
				return i;
		end
		return n;
	endfunction

	function automatic tlwcs_pkg::result_t schedule_step(tlwcs_pkg::action_t act,
			logic ln, int fr, int to, int hc);
		tlwcs_pkg::result_t r;
		int n, idx, gate, start;
		bit live_has, back_has, use_live;
		r.status = tlwcs_pkg::ST_OK;
		r.index = '0;
		r.lane = 1'b0;
		r.first = 1'b0;
		n = eff_count();
		case (act)
			tlwcs_pkg::ACT_NEED: begin
				if (fr > to || to >= n) begin
					r.status = tlwcs_pkg::ST_REJECT;
				end else begin
					for (int i = fr; i <= to; i++) begin
						if (ln) back_map[i] = 1; else live_map[i] = 1;
					end
					if (ln) begin
						if (fr < back_hint) back_hint = fr;
					end else begin
						if (fr < live_hint) live_hint = fr;
					end
				end
			end
			tlwcs_pkg::ACT_ANNOUNCE: begin
				if (hc > NCH) hc = NCH;
				if (hc > boundary) boundary = hc;
			end
			tlwcs_pkg::ACT_PICK: begin
				live_has = lowest_pending(0, 0, n) < n;
				back_has = lowest_pending(1, 0, n) < n;
				use_live = live_has;
				if (use_live && back_has && (longint'(back_total) * live_share_r <
						longint'(live_total) * back_share_r))
					use_live = 0;
				if (use_live ? !live_has : !back_has) begin
					r.status = tlwcs_pkg::ST_EMPTY;
				end else begin
					start = use_live ? live_hint : back_hint;
					if (start > n) start = n;
					idx = lowest_pending(!use_live, start, n);
					if (idx >= n) idx = lowest_pending(!use_live, 0, n);
					if (use_live) live_hint = idx; else back_hint = idx;
					gate = hashes_pre_r ? n : int'(boundary);
					if (idx >= gate) begin
						r.status = tlwcs_pkg::ST_WAIT;
					end else begin
						r.index = idx[tlwcs_pkg::IDX_W-1:0];
						r.lane = !use_live;
						r.first = !sent_map[idx];
						sent_map[idx] = 1;
						if (use_live) begin
							live_map[idx] = 0;
							if (live_total != 32'hFFFFFFFF) live_total++;
						end else begin
							back_map[idx] = 0;
							if (back_total != 32'hFFFFFFFF) back_total++;
						end
					end
				end
			end
			default: r.status = tlwcs_pkg::ST_REJECT;
		endcase
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		tlwcs_pkg::result_t e;
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result status=%0d index=%0d", $time, status,
					chunk_index);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (status !== e.status || chunk_index !== e.index ||
						chunk_lane !== e.lane || first_time !== e.first) begin
					$display({"%0t: mismatch expected st=%0d idx=%0d lane=%0d first=%0d,",
						" actual st=%0d idx=%0d lane=%0d first=%0d"},
						$time, e.status, e.index, e.lane, e.first,
						status, chunk_index, chunk_lane, first_time);
					errors++;
				end
			end
		end
	end

	// receiver: random pops, short random stalls and one long hold-off on demand
	always @(posedge clk) begin
		if (long_stall_req && !long_stall_done) begin
			long_stall_done <= 1'b1;
			stall_len <= 2000;
			pop <= 1'b0;
		end else if (stall_len > 0) begin
			stall_len <= stall_len - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 9) < 7);
			if ($urandom_range(0, 199) == 0) stall_len <= $urandom_range(20, 120);
		end
	end

	task automatic send_item(tlwcs_pkg::action_t act, logic ln, int fr, int to, int hc);
		int gap;
		gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 60);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		lane <= ln;
		range_from <= fr[tlwcs_pkg::IDX_W-1:0];
		range_to <= to[tlwcs_pkg::IDX_W-1:0];
		hash_count <= hc[tlwcs_pkg::CNT_W-1:0];
		@(posedge clk);
		while (full) @(posedge clk);
		expected_q.insert(expected_q.size(), schedule_step(act, ln, fr, to, hc));
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(tlwcs_pkg::cfg_idx_t idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[tlwcs_pkg::CNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			tlwcs_pkg::CFG_CHUNK_COUNT: chunk_count_r = value[tlwcs_pkg::CNT_W-1:0];
			tlwcs_pkg::CFG_BACKFILL_SHARE: back_share_r = value[tlwcs_pkg::SHARE_W-1:0];
			tlwcs_pkg::CFG_LIVE_SHARE: live_share_r = value[tlwcs_pkg::SHARE_W-1:0];
			tlwcs_pkg::CFG_HASHES_PRE: hashes_pre_r = value[0];
			default: begin
			end
		endcase
	endtask

	task automatic send_random_item(int n);
		int r, fr, to;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			fr = $urandom_range(0, (n > 0) ? n - 1 : 0);
			to = fr + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) :
				$urandom_range(0, 8));
			if ($urandom_range(0, 9) == 0) to = $urandom_range(0, NCH - 1);
			if (to > NCH - 1) to = NCH - 1;
			send_item(tlwcs_pkg::ACT_NEED, $urandom_range(0, 1), fr, to,
				$urandom_range(0, 8191));
		end else if (r < 45) begin
			send_item(tlwcs_pkg::ACT_ANNOUNCE, $urandom_range(0, 1), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 8191));
		end else if (r < 97) begin
			send_item(tlwcs_pkg::ACT_PICK, $urandom_range(0, 1), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 8191));
		end else begin
			send_item(tlwcs_pkg::ACT_UNUSED, $urandom_range(0, 1), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 8191));
		end
	endtask

	task automatic test_directed();
		send_item(tlwcs_pkg::ACT_PICK, 0, 0, 0, 0);
		send_item(tlwcs_pkg::ACT_NEED, 0, 5, 3, 0);
		send_item(tlwcs_pkg::ACT_NEED, 1, 0, 4096 - 1, 0);
		send_item(tlwcs_pkg::ACT_NEED, 0, 4095, 4095, 0);
		send_item(tlwcs_pkg::ACT_NEED, 0, 0, 2, 0);
		send_item(tlwcs_pkg::ACT_PICK, 1, 0, 0, 0);
		send_item(tlwcs_pkg::ACT_ANNOUNCE, 0, 0, 0, 8191);
		send_item(tlwcs_pkg::ACT_ANNOUNCE, 0, 0, 0, 2);
		for (int i = 0; i < 6; i++) send_item(tlwcs_pkg::ACT_PICK, 0, 0, 0, 0);
		send_item(tlwcs_pkg::ACT_UNUSED, 1, 4095, 4095, 8191);
		send_item(tlwcs_pkg::ACT_NEED, 0, 0, 0, 0);
		send_item(tlwcs_pkg::ACT_PICK, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_small_volume();
		write_reg(tlwcs_pkg::CFG_CHUNK_COUNT, 40);
		write_reg(tlwcs_pkg::CFG_BACKFILL_SHARE, 15);
		write_reg(tlwcs_pkg::CFG_LIVE_SHARE, 1);
		write_reg(tlwcs_pkg::CFG_HASHES_PRE, 1);
		for (int i = 0; i < 150; i++) send_random_item(40);
		drain();
	endtask

	task automatic test_zero_count();
		write_reg(tlwcs_pkg::CFG_CHUNK_COUNT, 0);
		write_reg(tlwcs_pkg::CFG_HASHES_PRE, 0);
		write_reg(tlwcs_pkg::CFG_BACKFILL_SHARE, 0);
		write_reg(tlwcs_pkg::CFG_LIVE_SHARE, 15);
		send_item(tlwcs_pkg::ACT_NEED, 0, 0, 0, 0);
		send_item(tlwcs_pkg::ACT_PICK, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_gated();
		write_reg(tlwcs_pkg::CFG_CHUNK_COUNT, 200);
		write_reg(tlwcs_pkg::CFG_BACKFILL_SHARE, 3);
		write_reg(tlwcs_pkg::CFG_LIVE_SHARE, 7);
		for (int i = 0; i < 150; i++) send_random_item(200);
		drain();
	endtask

	task automatic test_full_stall();
		write_reg(tlwcs_pkg::CFG_CHUNK_COUNT, 8191);
		write_reg(tlwcs_pkg::CFG_HASHES_PRE, 1);
		write_reg(tlwcs_pkg::CFG_LIVE_SHARE, 0);
		long_stall_req = 1'b1;
		for (int i = 0; i < 20; i++) send_item(tlwcs_pkg::ACT_ANNOUNCE, 0, 0, 0, i);
		drain();
		for (int i = 0; i < 150; i++) send_random_item(4096);
		drain();
	endtask

	initial begin
		arst_n = 0;
		push = 0; action = 0; lane = 0; range_from = 0; range_to = 0;
		hash_count = 0; cfg_we = 0; cfg_index = tlwcs_pkg::CFG_CHUNK_COUNT; cfg_data = 0;
		chunk_count_r = tlwcs_pkg::CHUNK_COUNT_RST;
		back_share_r = tlwcs_pkg::BACKFILL_SHARE_RST;
		live_share_r = tlwcs_pkg::LIVE_SHARE_RST;
		hashes_pre_r = 0;
		live_hint = 0; back_hint = 0; live_total = 0; back_total = 0; boundary = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_small_volume();
		test_zero_count();
		test_gated();
		test_full_stall();
		if (errors == 0)
			$display("two_lane_weighted_chunk_scheduler regression: pass");
		else
			$display("two_lane_weighted_chunk_scheduler regression: fail");
		$finish;
	end

endmodule
